// ----- design/icon_pixel_color_effect_unit_macros.svh -----
// Assertion macros used by the icon pixel color effect sequencer RTL.
`ifndef ICON_PIXEL_COLOR_EFFECT_UNIT_MACROS_SVH
`define ICON_PIXEL_COLOR_EFFECT_UNIT_MACROS_SVH

// Check a property on every rising edge outside reset.
`define ICPE_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("icpe: assertion failed");

// Check that a condition implies another in the following cycle.
`define ICPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("icpe: assertion failed");

`endif

// ----- design/icpe_pkg.sv -----
// Types and constants of the icon pixel color effect unit.
`default_nettype none
package icpe_pkg;

  localparam int MAC_W = 17;
  localparam int ACC_W = 34;
  localparam int SUM_W = 32;

  localparam logic [1:0] MODE_NONE     = 2'd0;
  localparam logic [1:0] MODE_GRAY     = 2'd1;
  localparam logic [1:0] MODE_COLORIZE = 2'd2;
  localparam logic [1:0] MODE_MONO     = 2'd3;

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_APPLY   = 1'b1;

  localparam logic [2:0] REG_MODE         = 3'd0;
  localparam logic [2:0] REG_STRENGTH     = 3'd1;
  localparam logic [2:0] REG_FIRST_COLOR  = 3'd2;
  localparam logic [2:0] REG_SECOND_COLOR = 3'd3;
  localparam logic [2:0] REG_HALVE_ALPHA  = 3'd4;

  localparam logic [1:0]  MODE_RST         = 2'd0;
  localparam logic [8:0]  STRENGTH_RST     = 9'd256;
  localparam logic [23:0] FIRST_COLOR_RST  = 24'd9470200;
  localparam logic [23:0] SECOND_COLOR_RST = 24'd0;

  typedef struct packed {
    logic [1:0]  mode;
    logic [8:0]  strength;
    logic [23:0] first_color;
    logic [23:0] second_color;
    logic        halve_alpha;
  } cfg_t;

  typedef enum logic [1:0] {
    BASE_ZERO = 2'd0,
    BASE_ACC  = 2'd1,
    BASE_EXT  = 2'd2
  } base_sel_t;

  typedef struct packed {
    logic      en;
    base_sel_t base_sel;
  } mac_ctl_t;

  function automatic logic [7:0] chan_of(input logic [23:0] color, input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = color[23:16];
      2'd1:    c = color[15:8];
      default: c = color[7:0];
    endcase
    return c;
  endfunction

endpackage
`default_nettype wire

// ----- design/icpe_cfg.sv -----
// Configuration register file with APB-style access.
`default_nettype none
module icpe_cfg (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_psel,
  input  wire logic         cfg_penable,
  input  wire logic         cfg_pwrite,
  input  wire logic [4:0]   cfg_paddr,
  input  wire logic [31:0]  cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready,
  output icpe_pkg::cfg_t    cfg
);
  import icpe_pkg::*;

  cfg_t       cfg_r, cfg_nxt;
  logic [2:0] idx;
  logic       wr;

  assign idx        = cfg_paddr[4:2];
  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg        = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      unique case (idx)
        REG_MODE:         cfg_nxt.mode         = cfg_pwdata[1:0];
        REG_STRENGTH:     cfg_nxt.strength     = cfg_pwdata[8:0];
        REG_FIRST_COLOR:  cfg_nxt.first_color  = cfg_pwdata[23:0];
        REG_SECOND_COLOR: cfg_nxt.second_color = cfg_pwdata[23:0];
        REG_HALVE_ALPHA:  cfg_nxt.halve_alpha  = cfg_pwdata[0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MODE:         cfg_prdata = {30'd0, cfg_r.mode};
      REG_STRENGTH:     cfg_prdata = {23'd0, cfg_r.strength};
      REG_FIRST_COLOR:  cfg_prdata = {8'd0, cfg_r.first_color};
      REG_SECOND_COLOR: cfg_prdata = {8'd0, cfg_r.second_color};
      REG_HALVE_ALPHA:  cfg_prdata = {31'd0, cfg_r.halve_alpha};
      default:          cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode         <= MODE_RST;
      cfg_r.strength     <= STRENGTH_RST;
      cfg_r.first_color  <= FIRST_COLOR_RST;
      cfg_r.second_color <= SECOND_COLOR_RST;
      cfg_r.halve_alpha  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- design/icpe_mac.sv -----
// Shared multiply-accumulate unit.
`default_nettype none
module icpe_mac (
  input  wire logic                         clk,
  input  wire icpe_pkg::mac_ctl_t           ctl,
  input  wire logic [icpe_pkg::MAC_W-1:0]   a,
  input  wire logic [icpe_pkg::MAC_W-1:0]   b,
  input  wire logic [icpe_pkg::SUM_W-1:0]   ext_base,
  output logic      [icpe_pkg::ACC_W-1:0]   mac_sum,
  output logic      [icpe_pkg::ACC_W-1:0]   acc_r
);
  import icpe_pkg::*;

  logic [ACC_W-1:0] prod;
  logic [ACC_W-1:0] base;

  assign prod = a * b;

  always_comb begin
    unique case (ctl.base_sel)
      BASE_ZERO: base = '0;
      BASE_ACC:  base = acc_r;
      BASE_EXT:  base = ACC_W'(ext_base);
      default:   base = '0;
    endcase
  end

  assign mac_sum = base + prod;

  always_ff @(posedge clk) begin
    if (ctl.en) begin
      acc_r <= mac_sum;
    end
  end

endmodule
`default_nettype wire

// ----- design/icpe_seq.sv -----
// Sequencer: statistics, per-channel effect steps and the output register.
`default_nettype none
`include "icon_pixel_color_effect_unit_macros.svh"
module icpe_seq #(
  parameter int MAX_PIXELS = 4096,
  parameter int CNT_W      = 13
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire icpe_pkg::cfg_t               cfg,
  input  wire logic                         in_tvalid,
  output logic                              in_tready,
  input  wire logic [31:0]                  in_tdata,
  input  wire logic [1:0]                   in_tuser,
  output logic                              out_tvalid,
  input  wire logic                         out_tready,
  output logic [31:0]                       out_tdata,
  output icpe_pkg::mac_ctl_t                mac_ctl,
  output logic      [icpe_pkg::MAC_W-1:0]   mac_a,
  output logic      [icpe_pkg::MAC_W-1:0]   mac_b,
  output logic      [icpe_pkg::SUM_W-1:0]   mac_base,
  input  wire logic [icpe_pkg::ACC_W-1:0]   mac_sum,
  input  wire logic [icpe_pkg::ACC_W-1:0]   acc_r
);
  import icpe_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MEAS1 = 9'b000000010,
    S_MEAS2 = 9'b000000100,
    S_DARK  = 9'b000001000,
    S_PRE1  = 9'b000010000,
    S_PRE2  = 9'b000100000,
    S_E1    = 9'b001000000,
    S_E2    = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt, chan_start;
  logic [1:0]       ch_r, ch_nxt;
  logic [7:0]       red_r, red_nxt, green_r, green_nxt, blue_r, blue_nxt;
  logic [7:0]       alpha_r, alpha_nxt;
  logic [7:0]       res0_r, res0_nxt, res1_r, res1_nxt, res2_r, res2_nxt;
  logic             dark_r, dark_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [31:0]      out_data_r, out_data_nxt;
  logic [SUM_W-1:0] sum_r, sum_nxt;
  logic [CNT_W-1:0] count_r, count_nxt, base_cnt;
  logic             all_gray_r, all_gray_nxt;

  logic [12:0]      gray_w;
  logic [7:0]       gray;
  logic [15:0]      g255;
  logic [8:0]       s, ns;
  logic [16:0]      ns255;
  logic [7:0]       c_first, c_second, o;
  logic [16:0]      tint_hi_sum;
  logic [7:0]       tint;
  logic [15:0]      eff;
  logic [15:0]      y;
  logic [16:0]      y_q;
  logic [7:0]       ch_res;
  logic             mono_gray;
  logic             out_free;

  assign gray_w   = 13'(11 * red_r) + {green_r, 4'b0} + 13'(5 * blue_r);
  assign gray     = gray_w[12:5];
  assign g255     = {gray, 8'h00} - {8'h00, gray};
  assign s        = (cfg.strength > 9'd256) ? 9'd256 : cfg.strength;
  assign ns       = 9'd256 - s;
  assign ns255    = {ns, 8'h00} - {8'h00, ns};
  assign c_first  = chan_of(cfg.first_color, ch_r);
  assign c_second = chan_of(cfg.second_color, ch_r);
  assign o        = (ch_r == 2'd0) ? red_r : ((ch_r == 2'd1) ? green_r : blue_r);
  assign mono_gray = (cfg.mode == MODE_MONO) && all_gray_r;
  assign base_cnt = in_tuser[1] ? '0 : count_r;
  assign out_free = !out_valid_r || out_tready;

  assign tint_hi_sum = acc_r[16:0] + {2'b00, c_first, 7'b0} - 17'd128;
  always_comb begin
    if (gray < 8'd128) begin
      tint = acc_r[14:7];
    end else if (gray == 8'd128) begin
      tint = c_first;
    end else begin
      tint = tint_hi_sum[14:7];
    end
  end

  always_comb begin
    case (cfg.mode)
      MODE_GRAY:     eff = {8'h00, gray};
      MODE_COLORIZE: eff = {8'h00, tint};
      MODE_MONO:     eff = all_gray_r ? acc_r[15:0] : {8'h00, (dark_r ? c_first : c_second)};
      default:       eff = {8'h00, o};
    endcase
  end

  assign y      = mac_sum[23:8];
  assign y_q    = {1'b0, y} + {9'd0, y[15:8]} + 17'd1;
  assign ch_res = mono_gray ? y_q[15:8] : mac_sum[15:8];

  assign chan_start = ((cfg.mode == MODE_COLORIZE) || mono_gray) ? S_PRE1 : S_E1;

  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    red_nxt       = red_r;
    green_nxt     = green_r;
    blue_nxt      = blue_r;
    alpha_nxt     = alpha_r;
    res0_nxt      = res0_r;
    res1_nxt      = res1_r;
    res2_nxt      = res2_r;
    dark_nxt      = dark_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    sum_nxt       = sum_r;
    count_nxt     = count_r;
    all_gray_nxt  = all_gray_r;
    mac_ctl.en       = 1'b0;
    mac_ctl.base_sel = BASE_ZERO;
    mac_a         = '0;
    mac_b         = '0;
    mac_base      = sum_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          red_nxt   = in_tdata[7:0];
          green_nxt = in_tdata[15:8];
          blue_nxt  = in_tdata[23:16];
          alpha_nxt = in_tdata[31:24];
          ch_nxt    = 2'd0;
          if (in_tuser[0] == KIND_MEASURE) begin
            if (in_tuser[1]) begin
              sum_nxt      = '0;
              count_nxt    = '0;
              all_gray_nxt = 1'b1;
            end
            if (base_cnt < CNT_W'(MAX_PIXELS)) begin
              count_nxt    = base_cnt + 1'b1;
              all_gray_nxt = (in_tuser[1] | all_gray_r) &
                             (in_tdata[7:0] == in_tdata[15:8]) &
                             (in_tdata[15:8] == in_tdata[23:16]);
              state_nxt    = S_MEAS1;
            end
          end else if (cfg.mode == MODE_NONE) begin
            state_nxt = S_FIN;
          end else if ((cfg.mode == MODE_MONO) && !all_gray_r) begin
            state_nxt = S_DARK;
          end else begin
            state_nxt = chan_start;
          end
        end
      end
      S_MEAS1: begin
        mac_ctl.en       = 1'b1;
        mac_ctl.base_sel = BASE_EXT;
        mac_a     = MAC_W'(gray);
        mac_b     = MAC_W'(alpha_r);
        state_nxt = S_MEAS2;
      end
      S_MEAS2: begin
        mac_ctl.en       = 1'b1;
        mac_ctl.base_sel = BASE_ACC;
        mac_a     = MAC_W'(8'd255);
        mac_b     = MAC_W'(8'd255 - alpha_r);
        sum_nxt   = mac_sum[SUM_W-1:0];
        state_nxt = S_IDLE;
      end
      S_DARK: begin
        mac_a     = MAC_W'(g255);
        mac_b     = MAC_W'(count_r);
        dark_nxt  = mac_sum <= ACC_W'(sum_r);
        state_nxt = chan_start;
      end
      S_PRE1: begin
        mac_ctl.en = 1'b1;
        if (cfg.mode == MODE_COLORIZE) begin
          if (gray < 8'd128) begin
            mac_a = MAC_W'(c_first);
            mac_b = MAC_W'(gray);
          end else begin
            mac_a = MAC_W'(9'd256 - {1'b0, c_first});
            mac_b = MAC_W'(gray - 8'd128);
          end
          state_nxt = S_E1;
        end else begin
          mac_a     = MAC_W'(8'd255 - red_r);
          mac_b     = MAC_W'(c_first);
          state_nxt = S_PRE2;
        end
      end
      S_PRE2: begin
        mac_ctl.en       = 1'b1;
        mac_ctl.base_sel = BASE_ACC;
        mac_a     = MAC_W'(red_r);
        mac_b     = MAC_W'(c_second);
        state_nxt = S_E1;
      end
      S_E1: begin
        mac_ctl.en = 1'b1;
        mac_a     = MAC_W'(s);
        mac_b     = MAC_W'(eff);
        state_nxt = S_E2;
      end
      S_E2: begin
        mac_ctl.en       = 1'b1;
        mac_ctl.base_sel = BASE_ACC;
        mac_a = mono_gray ? ns255 : MAC_W'(ns);
        mac_b = MAC_W'(o);
        case (ch_r)
          2'd0:    res0_nxt = ch_res;
          2'd1:    res1_nxt = ch_res;
          default: res2_nxt = ch_res;
        endcase
        if (ch_r == 2'd2) begin
          state_nxt = S_FIN;
        end else begin
          ch_nxt    = ch_r + 2'd1;
          state_nxt = chan_start;
        end
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt[31:24] = cfg.halve_alpha ? {1'b0, alpha_r[7:1]} : alpha_r;
          if (cfg.mode == MODE_NONE) begin
            out_data_nxt[23:0] = {blue_r, green_r, red_r};
          end else begin
            out_data_nxt[23:0] = {res2_r, res1_r, res0_r};
          end
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_tready  = state_r == S_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ch_r        <= 2'd0;
      out_valid_r <= 1'b0;
      sum_r       <= '0;
      count_r     <= '0;
      all_gray_r  <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      ch_r        <= ch_nxt;
      out_valid_r <= out_valid_nxt;
      sum_r       <= sum_nxt;
      count_r     <= count_nxt;
      all_gray_r  <= all_gray_nxt;
    end
  end

  always_ff @(posedge clk) begin
    red_r      <= red_nxt;
    green_r    <= green_nxt;
    blue_r     <= blue_nxt;
    alpha_r    <= alpha_nxt;
    res0_r     <= res0_nxt;
    res1_r     <= res1_nxt;
    res2_r     <= res2_nxt;
    dark_r     <= dark_nxt;
    out_data_r <= out_data_nxt;
  end

  `ICPE_ASSERT(a_ch_range, clk, rst_n, ch_r <= 2'd2)
  `ICPE_ASSERT(a_count_max, clk, rst_n, count_r <= CNT_W'(MAX_PIXELS))
  `ICPE_ASSERT_NEXT(a_fin_loads, clk, rst_n, state_r == S_FIN && out_free, out_valid_r)
  `ICPE_ASSERT_NEXT(a_measure_silent, clk, rst_n,
    state_r == S_IDLE && in_tvalid && in_tuser[0] == KIND_MEASURE,
    state_r == S_IDLE || state_r == S_MEAS1)

endmodule
`default_nettype wire

// ----- design/icon_pixel_color_effect_unit.sv -----
// Icon pixel color effect unit: sequencer, shared MAC and register file.
// Usage:
//   in_*  : stream of RGBA pixels. tuser[0] selects measure (0) or apply (1),
//           tuser[1] on a measure pixel clears the brightness statistics.
//   out_* : one processed RGBA pixel per apply pixel; measure pixels give none.
//   cfg_* : APB-style register port; write only while the block is idle.
// Steps, all through one shared 17x17 multiply-accumulate unit:
//   measure pixel: accept, two MAC steps into the sum (none once the count is at MAX_PIXELS).
//   apply pixel: accept, the mean compare in monochrome by mean, then the
//   channel steps unless the mode is none, then the output register.
//   Each color channel takes two MAC steps for the blend, one more for the
//   tint and two more for the gray two-tone mix; the mean compare takes one.
// in_tready is high only while the sequencer is idle. A finished result sits
// in the output register; a new pixel is accepted while it waits, and the
// next result is held in the sequencer until out_tready frees the register.
// Reset clears the statistics (sum and count zero, all-gray set), empties
// the output register and loads the register defaults.
`default_nettype none
module icon_pixel_color_effect_unit #(
  parameter int MAX_PIXELS = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,    // in_red, in_green, in_blue, in_alpha
  input  wire logic [1:0]  in_tuser,    // kind, first
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,   // out_red, out_green, out_blue, out_alpha
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);
  import icpe_pkg::*;

  localparam int CNT_W = $clog2(MAX_PIXELS + 1);

  cfg_t             cfg;
  mac_ctl_t         mac_ctl;
  logic [MAC_W-1:0] mac_a, mac_b;
  logic [SUM_W-1:0] mac_base;
  logic [ACC_W-1:0] mac_sum, acc_r;

  icpe_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  icpe_mac u_mac (
    .clk      (clk),
    .ctl      (mac_ctl),
    .a        (mac_a),
    .b        (mac_b),
    .ext_base (mac_base),
    .mac_sum  (mac_sum),
    .acc_r    (acc_r)
  );

  icpe_seq #(
    .MAX_PIXELS (MAX_PIXELS),
    .CNT_W      (CNT_W)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .mac_ctl    (mac_ctl),
    .mac_a      (mac_a),
    .mac_b      (mac_b),
    .mac_base   (mac_base),
    .mac_sum    (mac_sum),
    .acc_r      (acc_r)
  );

endmodule
`default_nettype wire
